FILE: rtl/core/slpg_pkg.sv
// ----------------------------------------------------------------------------
// slpg_pkg
// Shared types and constants of the status LED pattern generator.
// ----------------------------------------------------------------------------
package slpg_pkg;

   typedef enum logic [3:0] {
      MODE_IDLE     = 4'd0,
      MODE_SETUP    = 4'd1,
      MODE_OPENING  = 4'd2,
      MODE_CLOSING  = 4'd3,
      MODE_MANUAL   = 4'd4,
      MODE_CFGOPEN  = 4'd5,
      MODE_CFGCLOSE = 4'd6,
      MODE_SAVED    = 4'd7,
      MODE_ERROR    = 4'd8
   } mode_type;

   typedef enum logic {
      OP_TICK     = 1'b0,
      OP_SET_MODE = 1'b1
   } op_type;

   localparam int PHASE_W   = 11;
   localparam int ELAPSED_W = 12;
   localparam int LEVEL_W   = 8;

   localparam logic [PHASE_W-1:0]   PHASE_LAST    = 11'd1999;
   localparam logic [PHASE_W-1:0]   PHASE_HALF    = 11'd1000;
   localparam logic [ELAPSED_W-1:0] ELAPSED_MAX   = 12'd4095;
   localparam logic [ELAPSED_W-1:0] SAVED_HOLD_MS = 12'd2000;
   localparam logic [ELAPSED_W-1:0] ERROR_HOLD_MS = 12'd3000;

   localparam logic [LEVEL_W-1:0] LEVEL_OFF  = 8'd0;
   localparam logic [LEVEL_W-1:0] LEVEL_FULL = 8'd255;

   // One tick on its way to the color stage: mode before fallback, new phase.
   typedef struct packed {
      logic                valid;
      mode_type            mode;
      logic [PHASE_W-1:0]  phase;
   } stage_type;

endpackage

FILE: rtl/core/slpg_req_if.sv
// ----------------------------------------------------------------------------
// slpg_req_if
// Request channel: tick or set-mode beats.
// ----------------------------------------------------------------------------
interface slpg_req_if;
   logic       valid;
   logic       ready;
   logic       operation;
   logic [3:0] new_mode;

   modport source (output valid, output operation, output new_mode, input ready);
   modport sink   (input valid, input operation, input new_mode, output ready);
endinterface

FILE: rtl/core/slpg_rsp_if.sv
// ----------------------------------------------------------------------------
// slpg_rsp_if
// Response channel: one RGB beat per tick.
// ----------------------------------------------------------------------------
interface slpg_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] red_level;
   logic [7:0] green_level;
   logic [7:0] blue_level;

   modport source (output valid, output red_level, output green_level,
                   output blue_level, input ready);
   modport sink   (input valid, input red_level, input green_level,
                   input blue_level, output ready);
endinterface

FILE: rtl/core/slpg_state.sv
// ----------------------------------------------------------------------------
// slpg_state
// Mode, phase and time-in-mode registers, plus the tick stage register.
// ----------------------------------------------------------------------------
module slpg_state (
   input  logic                clock,
   input  logic                reset,
   input  logic                fire,
   input  logic                operation,
   input  logic [3:0]          new_mode,
   input  logic                take,
   output slpg_pkg::stage_type stage
);
   import slpg_pkg::*;

   mode_type               mode_ff, mode_in;
   logic [PHASE_W-1:0]     phase_ff, phase_in;
   logic [ELAPSED_W-1:0]   elapsed_ff, elapsed_in, elapsed_inc;
   stage_type              stage_ff, stage_in;
   logic                   is_set;
   logic                   hold_done;

   assign is_set = (operation == OP_SET_MODE);
   assign elapsed_inc = (elapsed_ff == ELAPSED_MAX) ? elapsed_ff : elapsed_ff + 12'd1;
   assign hold_done = ((mode_ff == MODE_SAVED) && (elapsed_inc >= SAVED_HOLD_MS)) ||
                      ((mode_ff == MODE_ERROR) && (elapsed_inc >= ERROR_HOLD_MS));

   always_comb begin
      mode_in    = mode_ff;
      phase_in   = phase_ff;
      elapsed_in = elapsed_ff;
      if (fire) begin
         if (is_set) begin
            // undefined codes fall back to idle
            mode_in    = (new_mode <= 4'(MODE_ERROR)) ? mode_type'(new_mode) : MODE_IDLE;
            elapsed_in = '0;
         end else begin
            phase_in   = (phase_ff == PHASE_LAST) ? '0 : phase_ff + 11'd1;
            elapsed_in = elapsed_inc;
            if (hold_done) begin
               mode_in    = MODE_IDLE;
               elapsed_in = '0;
            end
         end
      end
   end

   always_comb begin
      stage_in = stage_ff;
      if (take) begin
         stage_in.valid = 1'b0;
      end
      if (fire && !is_set) begin
         stage_in.valid = 1'b1;
         stage_in.mode  = mode_ff;   // color uses the mode before fallback
         stage_in.phase = phase_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff        <= MODE_IDLE;
         phase_ff       <= '0;
         elapsed_ff     <= '0;
         stage_ff.valid <= 1'b0;
      end else begin
         mode_ff        <= mode_in;
         phase_ff       <= phase_in;
         elapsed_ff     <= elapsed_in;
         stage_ff.valid <= stage_in.valid;
      end
      stage_ff.mode  <= stage_in.mode;
      stage_ff.phase <= stage_in.phase;
   end

   assign stage = stage_ff;

endmodule

FILE: rtl/core/slpg_color.sv
// ----------------------------------------------------------------------------
// slpg_color
// Maps mode and phase to an RGB level and holds it in the response register.
// ----------------------------------------------------------------------------
module slpg_color (
   input  logic                clock,
   input  logic                reset,
   input  slpg_pkg::stage_type stage,
   output logic                take,
   slpg_rsp_if.source          rsp
);
   import slpg_pkg::*;

   // floor(n*255/333) = (n * ceil(255*2^22/333)) >> 22, exact for n <= 334
   localparam logic [30:0] FADE_RECIP   = 31'd3211855;
   // floor(q*80/255) = (q * 20561) >> 16, exact for q <= 127
   localparam logic [21:0] MANUAL_RECIP = 22'd20561;

   logic [9:0]            phase_mod;
   logic [9:0]            fade_dist;
   logic [30:0]           fade_prod;
   logic [8:0]            fade_quot;
   logic [LEVEL_W-1:0]    fade_lvl;
   logic [7:0]            ramp;
   logic [6:0]            tri_lvl;
   logic [21:0]           manual_prod;
   logic [LEVEL_W-1:0]    red_in, green_in, blue_in;
   logic [LEVEL_W-1:0]    red_ff, green_ff, blue_ff;
   logic                  valid_ff;

   assign phase_mod = (stage.phase >= PHASE_HALF) ? 10'(stage.phase - PHASE_HALF)
                                                  : stage.phase[9:0];

   assign fade_dist = (phase_mod < 10'd666) ? phase_mod - 10'd333 : 10'd1000 - phase_mod;
   assign fade_prod = {22'd0, fade_dist[8:0]} * FADE_RECIP;
   assign fade_quot = fade_prod[30:22];
   assign fade_lvl  = fade_quot[8] ? LEVEL_FULL : fade_quot[7:0];

   // triangle wave: phase/8 folded at 127
   assign ramp        = stage.phase[10:3];
   assign tri_lvl     = (ramp > 8'd127) ? 7'(8'd255 - ramp) : ramp[6:0];
   assign manual_prod = {15'd0, tri_lvl} * MANUAL_RECIP;

   always_comb begin
      red_in   = LEVEL_OFF;
      green_in = LEVEL_OFF;
      blue_in  = LEVEL_OFF;
      unique case (stage.mode)
         MODE_SETUP: begin
            blue_in = LEVEL_FULL;
         end
         MODE_OPENING: begin
            green_in = LEVEL_FULL;
         end
         MODE_CLOSING: begin
            red_in   = LEVEL_FULL;
            green_in = LEVEL_FULL;
         end
         MODE_MANUAL: begin
            red_in   = {1'b0, tri_lvl};
            green_in = {2'b00, manual_prod[21:16]};
         end
         MODE_CFGOPEN: begin
            green_in = LEVEL_FULL;
            if (phase_mod >= 10'd333) begin
               red_in  = fade_lvl;
               blue_in = fade_lvl;
            end
         end
         MODE_CFGCLOSE: begin
            red_in   = LEVEL_FULL;
            green_in = LEVEL_FULL;
            if (phase_mod >= 10'd333) begin
               blue_in = fade_lvl;
            end
         end
         MODE_SAVED: begin
            if ((phase_mod < 10'd250) || ((phase_mod >= 10'd500) && (phase_mod < 10'd750))) begin
               green_in = LEVEL_FULL;
               blue_in  = LEVEL_FULL;
            end
         end
         MODE_ERROR: begin
            red_in = LEVEL_FULL;
         end
         default: begin
            red_in = LEVEL_OFF;
         end
      endcase
   end

   assign take = !valid_ff || rsp.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (take) begin
         valid_ff <= stage.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (take && stage.valid) begin
         red_ff   <= red_in;
         green_ff <= green_in;
         blue_ff  <= blue_in;
      end
   end

   assign rsp.valid       = valid_ff;
   assign rsp.red_level   = red_ff;
   assign rsp.green_level = green_ff;
   assign rsp.blue_level  = blue_ff;

endmodule

FILE: rtl/core/status_led_pattern_generator_core.sv
// ----------------------------------------------------------------------------
// status_led_pattern_generator_core
// Status LED color generator: set-mode and 1 ms tick beats in, RGB beats out.
// ----------------------------------------------------------------------------
//  channel  dir  payload                                  beat
//  req_ch   in   operation, new_mode                      tick or set-mode
//  rsp_ch   out  red_level, green_level, blue_level       one per tick
//
//  One request beat per cycle while req_ch.ready is high; a tick's color passes
//  through the tick stage register, then the response register.
//  Mode, phase and time-in-mode update in the cycle a beat is taken.
//  A stalled response backs up into the tick stage; req_ch.ready drops only
//  when both registers are full and rsp_ch.ready is low.
//  Synchronous reset: idle mode, phase and time-in-mode zero, both stages empty.
// ----------------------------------------------------------------------------
module status_led_pattern_generator_core (
   input  logic        clock,
   input  logic        reset,
   slpg_req_if.sink    req_ch,
   slpg_rsp_if.source  rsp_ch
);
   import slpg_pkg::*;

   stage_type stage;
   logic      take;
   logic      fire;

   assign req_ch.ready = !stage.valid || take;
   assign fire         = req_ch.valid && req_ch.ready;

   slpg_state u_state (
      .clock     (clock),
      .reset     (reset),
      .fire      (fire),
      .operation (req_ch.operation),
      .new_mode  (req_ch.new_mode),
      .take      (take),
      .stage     (stage)
   );

   slpg_color u_color (
      .clock (clock),
      .reset (reset),
      .stage (stage),
      .take  (take),
      .rsp   (rsp_ch)
   );

   a_tick_staged : assert property (@(posedge clock) disable iff (reset)
      fire && (req_ch.operation == OP_TICK) |=> stage.valid && (stage.phase <= PHASE_LAST))
      else $error("accepted tick did not reach the stage register");

   a_set_no_beat : assert property (@(posedge clock) disable iff (reset)
      fire && (req_ch.operation == OP_SET_MODE) && (!stage.valid || take) |=> !stage.valid)
      else $error("set-mode beat produced a tick stage entry");

   a_stage_holds : assert property (@(posedge clock) disable iff (reset)
      stage.valid && !take |=> stage.valid && $stable(stage.phase) && $stable(stage.mode))
      else $error("stalled tick stage lost or changed its entry");

endmodule
